@@ rtl/core/ucep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint zero sequencer package
// Shared constants, event codes and the request and result records.
// ----------------------------------------------------------------------------
package ucep_pkg;

    localparam int unsigned MAX_PACKET = 64;
    localparam int unsigned BUF_BYTES  = 128;

    localparam logic [6:0]  MAX_PACKET_LEN = 7'(MAX_PACKET);
    localparam logic [15:0] BUF_SIZE       = 16'(BUF_BYTES);

    localparam logic [1:0] ACT_SETUP    = 2'd0;
    localparam logic [1:0] ACT_PACKET   = 2'd1;
    localparam logic [1:0] ACT_TX_FREE  = 2'd2;
    localparam logic [1:0] ACT_REPLY    = 2'd3;

    typedef enum logic [1:0] {
        EV_SETUP,
        EV_PACKET,
        EV_TX_FREE,
        EV_REPLY
    } ev_t;

    typedef struct packed {
        ev_t         ev;
        logic        dir_in;
        logic [15:0] request_length;
        logic        zero_len;
        logic [6:0]  packet_len;
        logic        tx_free;
        logic        handled;
        logic [15:0] reply_clip;
    } cmd_t;

    typedef struct packed {
        logic       stall_res;
        logic       send;
        logic [7:0] send_offset;
        logic [6:0] send_len;
        logic       request_ready;
        logic [7:0] store_offset;
        logic [6:0] store_len;
        logic       status_done;
    } res_t;

endpackage

@@ rtl/core/ucep_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint zero sequencer front end
// Classifies each incoming event and prepares its state-independent fields.
// ----------------------------------------------------------------------------
module ucep_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic                  dir_in,
    input  logic [15:0]           request_length,
    input  logic [6:0]            packet_len,
    input  logic                  tx_free,
    input  logic                  handled,
    input  logic [7:0]            reply_len,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ucep_pkg::cmd_t        push_cmd
);
    import ucep_pkg::*;

    ev_t ev;

    always_comb
    begin
        unique case (action)
            ACT_SETUP:   ev = EV_SETUP;
            ACT_PACKET:  ev = EV_PACKET;
            ACT_TX_FREE: ev = EV_TX_FREE;
            ACT_REPLY:   ev = EV_REPLY;
            default:     ev = EV_REPLY;
        endcase
    end

    always_comb
    begin
        push_cmd.ev             = ev;
        push_cmd.dir_in         = dir_in;
        push_cmd.request_length = request_length;
        push_cmd.zero_len       = (request_length == 16'd0);
        push_cmd.packet_len     = packet_len;
        push_cmd.tx_free        = tx_free;
        push_cmd.handled        = handled;
        push_cmd.reply_clip     = ({8'd0, reply_len} < BUF_SIZE) ? {8'd0, reply_len} : BUF_SIZE;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

@@ rtl/core/ucep_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint zero sequencer request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ucep_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ucep_pkg::cmd_t    push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ucep_pkg::cmd_t    pop_cmd
);
    import ucep_pkg::*;

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count did not drop on pop");

endmodule

@@ rtl/core/ucep_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint zero sequencer back end
// Holds the transfer state, executes each request and registers its result.
// ----------------------------------------------------------------------------
module ucep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  ucep_pkg::cmd_t    pop_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output ucep_pkg::res_t    out_res
);
    import ucep_pkg::*;

    logic        direction_in_reg;
    logic        direction_in_next;
    logic [15:0] setup_length_reg;
    logic [15:0] setup_length_next;
    logic [15:0] byte_count_reg;
    logic [15:0] byte_count_next;
    logic        transfer_complete_reg;
    logic        transfer_complete_next;
    logic        awaiting_reply_reg;
    logic        awaiting_reply_next;
    logic        tx_active_reg;
    logic        tx_active_next;
    logic [15:0] tx_remaining_reg;
    logic [15:0] tx_remaining_next;
    logic        tx_truncated_reg;
    logic        tx_truncated_next;
    logic [7:0]  tx_position_reg;
    logic [7:0]  tx_position_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;
    res_t        res_next;

    logic        advance;
    logic [16:0] sum;
    logic [15:0] room;
    logic [6:0]  keep;
    logic [15:0] reply_n;
    logic        reply_mode;
    logic [7:0]  src_pos;
    logic [15:0] src_rem;
    logic        src_trunc;
    logic [6:0]  chunk;
    logic [15:0] rem_after;
    logic [7:0]  pos_after;
    logic        stay_active;
    logic        out_too_long;
    logic        setup_too_long;

    assign advance   = pop_valid && (!out_valid_reg || out_ready);
    assign pop_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        sum     = {1'b0, byte_count_reg} + {10'd0, pop_cmd.packet_len};
        room    = BUF_SIZE - byte_count_reg;
        keep    = 7'd0;
        if (byte_count_reg < BUF_SIZE)
        begin
            keep = ({9'd0, pop_cmd.packet_len} < room) ? pop_cmd.packet_len : room[6:0];
        end
        reply_n = (pop_cmd.reply_clip > setup_length_reg) ? setup_length_reg
                                                          : pop_cmd.reply_clip;
        out_too_long   = !direction_in_reg && (setup_length_reg > BUF_SIZE);
        setup_too_long = !pop_cmd.dir_in && (pop_cmd.request_length > BUF_SIZE);

        reply_mode = (pop_cmd.ev == EV_REPLY);
        src_pos    = reply_mode ? 8'd0 : tx_position_reg;
        src_rem    = reply_mode ? (direction_in_reg ? reply_n : 16'd0) : tx_remaining_reg;
        src_trunc  = reply_mode ? (direction_in_reg && (reply_n < setup_length_reg))
                                : tx_truncated_reg;
        chunk       = (src_rem < {9'd0, MAX_PACKET_LEN}) ? src_rem[6:0] : MAX_PACKET_LEN;
        rem_after   = src_rem - {9'd0, chunk};
        pos_after   = src_pos + {1'b0, chunk};
        stay_active = !((rem_after == 16'd0) && (!src_trunc || (chunk < MAX_PACKET_LEN)));
    end

    always_comb
    begin
        direction_in_next      = direction_in_reg;
        setup_length_next      = setup_length_reg;
        byte_count_next        = byte_count_reg;
        transfer_complete_next = transfer_complete_reg;
        awaiting_reply_next    = awaiting_reply_reg;
        tx_active_next         = tx_active_reg;
        tx_remaining_next      = tx_remaining_reg;
        tx_truncated_next      = tx_truncated_reg;
        tx_position_next       = tx_position_reg;
        res_next               = '0;

        unique case (pop_cmd.ev)
            EV_SETUP:
            begin
                byte_count_next        = 16'd0;
                transfer_complete_next = 1'b0;
                tx_active_next         = 1'b0;
                awaiting_reply_next    = 1'b0;
                direction_in_next      = pop_cmd.dir_in;
                setup_length_next      = pop_cmd.request_length;
                if (pop_cmd.dir_in || pop_cmd.zero_len)
                begin
                    if (setup_too_long)
                    begin
                        res_next.stall_res     = 1'b1;
                        transfer_complete_next = 1'b1;
                    end
                    else
                    begin
                        res_next.request_ready = 1'b1;
                        awaiting_reply_next    = 1'b1;
                    end
                end
            end
            EV_PACKET:
            begin
                if (transfer_complete_reg || awaiting_reply_reg)
                begin
                    res_next.stall_res     = 1'b1;
                    transfer_complete_next = 1'b1;
                    awaiting_reply_next    = 1'b0;
                end
                else if (!direction_in_reg)
                begin
                    if (keep != 7'd0)
                    begin
                        res_next.store_offset = byte_count_reg[7:0];
                        res_next.store_len    = keep;
                    end
                    if (sum >= {1'b0, setup_length_reg})
                    begin
                        byte_count_next = setup_length_reg;
                        if (out_too_long)
                        begin
                            res_next.stall_res     = 1'b1;
                            transfer_complete_next = 1'b1;
                            awaiting_reply_next    = 1'b0;
                        end
                        else
                        begin
                            res_next.request_ready = 1'b1;
                            awaiting_reply_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_count_next = sum[15:0];
                    end
                end
                else
                begin
                    tx_active_next         = 1'b0;
                    transfer_complete_next = 1'b1;
                    res_next.status_done   = 1'b1;
                end
            end
            EV_TX_FREE:
            begin
                if (tx_active_reg && pop_cmd.tx_free)
                begin
                    res_next.send        = 1'b1;
                    res_next.send_offset = src_pos;
                    res_next.send_len    = chunk;
                    tx_position_next     = pos_after;
                    tx_remaining_next    = rem_after;
                    tx_active_next       = stay_active;
                end
            end
            EV_REPLY:
            begin
                if (awaiting_reply_reg)
                begin
                    awaiting_reply_next = 1'b0;
                    if (!pop_cmd.handled)
                    begin
                        res_next.stall_res     = 1'b1;
                        transfer_complete_next = 1'b1;
                    end
                    else
                    begin
                        tx_position_next  = src_pos;
                        tx_remaining_next = src_rem;
                        tx_truncated_next = src_trunc;
                        tx_active_next    = 1'b1;
                        if (pop_cmd.tx_free)
                        begin
                            res_next.send        = 1'b1;
                            res_next.send_offset = src_pos;
                            res_next.send_len    = chunk;
                            tx_position_next     = pos_after;
                            tx_remaining_next    = rem_after;
                            tx_active_next       = stay_active;
                        end
                        if (!direction_in_reg)
                        begin
                            transfer_complete_next = 1'b1;
                            res_next.status_done   = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_in_reg      <= 1'b0;
            setup_length_reg      <= 16'd0;
            byte_count_reg        <= 16'd0;
            transfer_complete_reg <= 1'b1;
            awaiting_reply_reg    <= 1'b0;
            tx_active_reg         <= 1'b0;
            tx_remaining_reg      <= 16'd0;
            tx_truncated_reg      <= 1'b0;
            tx_position_reg       <= 8'd0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                direction_in_reg      <= direction_in_next;
                setup_length_reg      <= setup_length_next;
                byte_count_reg        <= byte_count_next;
                transfer_complete_reg <= transfer_complete_next;
                awaiting_reply_reg    <= awaiting_reply_next;
                tx_active_reg         <= tx_active_next;
                tx_remaining_reg      <= tx_remaining_next;
                tx_truncated_reg      <= tx_truncated_next;
                tx_position_reg       <= tx_position_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_ready_xor_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.stall_res && res_reg.request_ready))
        else $error("request reported ready and stalled together");

    a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.send) |-> (res_reg.send_len <= MAX_PACKET_LEN))
        else $error("transmitted packet exceeds max packet size");

    a_wait_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reply_reg |-> !transfer_complete_reg)
        else $error("reply awaited with no transfer active");

    a_store_not_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.store_len != 7'd0)) |-> !res_reg.send)
        else $error("store and send on the same event");

endmodule

@@ rtl/core/usb_control_endpoint_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control endpoint zero sequencer
// Sequences setup, data and status stages of control transfers on endpoint 0.
//
// Each request on the input channel is one endpoint event: a setup packet,
// a packet from the host, a transmit-buffer-free event or the handler reply.
// Every request produces exactly one result on the output channel, which
// carries stall, transmit, store, request-ready and status-done indications.
// A front end classifies the request and writes it to a two-entry queue; the
// back end executes it against the transfer state and registers the result.
// A request is registered first in the queue and then in the result register
// of the back end; throughput is one request per cycle while the receiver
// accepts results. After reset no transfer is active and the queue and
// output register are empty. When the receiver stalls, the result register
// holds, the queue fills, and in_ready drops when the queue is full.
// ----------------------------------------------------------------------------
module usb_control_endpoint_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        dir_in,
    input  logic [15:0] request_length,
    input  logic [6:0]  packet_len,
    input  logic        tx_free,
    input  logic        handled,
    input  logic [7:0]  reply_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        stall_res,
    output logic        send,
    output logic [7:0]  send_offset,
    output logic [6:0]  send_len,
    output logic        request_ready,
    output logic [7:0]  store_offset,
    output logic [6:0]  store_len,
    output logic        status_done
);
    import ucep_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    res_t res;

    ucep_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .dir_in         (dir_in),
        .request_length (request_length),
        .packet_len     (packet_len),
        .tx_free        (tx_free),
        .handled        (handled),
        .reply_len      (reply_len),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    ucep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ucep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign stall_res     = res.stall_res;
    assign send          = res.send;
    assign send_offset   = res.send_offset;
    assign send_len      = res.send_len;
    assign request_ready = res.request_ready;
    assign store_offset  = res.store_offset;
    assign store_len     = res.store_len;
    assign status_done   = res.status_done;

endmodule
